/* hdl/pma_pkg.sv */
// shared types, constants and defaults of the 2d max/average pooling block
package pma_pkg;

    // default sizes handed to the top level parameters
    localparam int DEF_MAX_IMAGE  = 64;
    localparam int DEF_MAX_WINDOW = 8;
    localparam int DEF_DATA_BITS  = 16;

    // configuration register widths and reset values
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 7;
    localparam int IMG_REG_W  = 7;
    localparam int WIN_REG_W  = 4;
    localparam int STEP_REG_W = 4;

    localparam logic [IMG_REG_W-1:0]  IMAGE_SIZE_RST  = 7'd4;
    localparam logic [WIN_REG_W-1:0]  WINDOW_SIZE_RST = 4'd2;
    localparam logic [STEP_REG_W-1:0] STEP_RST        = 4'd2;
    localparam logic                  POOL_MODE_RST   = 1'b0;

    localparam logic POOL_MAX = 1'b0;
    localparam logic POOL_AVG = 1'b1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_IMAGE_SIZE  = 2'd0,
        REG_WINDOW_SIZE = 2'd1,
        REG_STEP        = 2'd2,
        REG_POOL_MODE   = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_LOAD,
        ST_DIV,
        ST_OUT
    } pma_state_t;

    // sequencer commands to the shared arithmetic unit
    typedef struct packed {
        logic clear;
        logic acc;
        logic load;
        logic step;
    } alu_ctrl_t;

endpackage

/* hdl/pool_2d_max_avg.sv */
// top level of the 2d max/average pooling block
//
// Pixels of a square image arrive in raster order as signed fixed-point values
// on the s_axis stream; each pixel that closes a pooling window (side
// window_size, origins every step pixels, window wholly inside the image)
// yields one result on the m_axis stream, the window maximum (pool_mode 0) or
// its average truncated toward zero (pool_mode 1); tlast marks the final
// result of an image. An image smaller than the window gives no results. A
// closing pixel starts a walk over the window, reading one stored pixel per
// cycle through the single read port of the row store; in average mode the
// sum then goes through the bit-serial divider, and the result is then handed
// over to the output register.
// The input is not ready while a window is being worked; a waiting result
// does not hold back pixels that close no window. Any configuration write
// restarts the image at row 0, column 0 and passes through the init state before the next
// pixel is taken; write registers only while the block is idle.
module pool_2d_max_avg import pma_pkg::*; #(
    parameter int MAX_IMAGE  = DEF_MAX_IMAGE,
    parameter int MAX_WINDOW = DEF_MAX_WINDOW,
    parameter int DATA_BITS  = DEF_DATA_BITS,
    localparam int TDATA_W   = ((DATA_BITS + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // pixel input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [TDATA_W-1:0]    s_axis_tdata,   // [DATA_BITS-1:0] pixel
    // pooled result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [TDATA_W-1:0]    m_axis_tdata,   // [DATA_BITS-1:0] pooled
    output logic                  m_axis_tlast    // last result of the image
);

    localparam int NW     = $clog2(MAX_IMAGE + 1);
    localparam int WW     = $clog2(MAX_WINDOW + 1);
    localparam int DEPTH  = MAX_IMAGE * MAX_WINDOW;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // configuration registers
    logic [IMG_REG_W-1:0]  image_size_reg;
    logic [WIN_REG_W-1:0]  window_size_reg;
    logic [STEP_REG_W-1:0] step_reg;
    logic                  pool_mode_reg;

    // effective (clamped) settings
    logic [NW-1:0]         img_n;
    logic [WW-1:0]         win_w;
    logic [STEP_REG_W-1:0] step_s;

    logic [ADDR_W-1:0]    mem_wr_addr, mem_rd_addr;
    logic                 mem_wr_en;
    logic [DATA_BITS-1:0] mem_rd_data;
    alu_ctrl_t            alu_ctrl;
    logic [DATA_BITS-1:0] alu_result;
    logic [DATA_BITS-1:0] m_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_size_reg  <= IMAGE_SIZE_RST;
            window_size_reg <= WINDOW_SIZE_RST;
            step_reg        <= STEP_RST;
            pool_mode_reg   <= POOL_MODE_RST;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_addr))
                REG_IMAGE_SIZE:  image_size_reg  <= cfg_wdata[IMG_REG_W-1:0];
                REG_WINDOW_SIZE: window_size_reg <= cfg_wdata[WIN_REG_W-1:0];
                REG_STEP:        step_reg        <= cfg_wdata[STEP_REG_W-1:0];
                REG_POOL_MODE:   pool_mode_reg   <= cfg_wdata[0];
                default:         pool_mode_reg   <= pool_mode_reg;
            endcase
        end
    end

    // zero acts as one, oversize values clamp to the build limits
    always_comb begin
        if (image_size_reg == '0) begin
            img_n = NW'(1);
        end else if (32'(image_size_reg) > MAX_IMAGE) begin
            img_n = NW'(MAX_IMAGE);
        end else begin
            img_n = NW'(image_size_reg);
        end
        if (window_size_reg == '0) begin
            win_w = WW'(1);
        end else if (32'(window_size_reg) > MAX_WINDOW) begin
            win_w = WW'(MAX_WINDOW);
        end else begin
            win_w = WW'(window_size_reg);
        end
        step_s = (step_reg == '0) ? STEP_REG_W'(1) : step_reg;
    end

    pma_ctrl #(
        .MAX_IMAGE  (MAX_IMAGE),
        .MAX_WINDOW (MAX_WINDOW),
        .DATA_BITS  (DATA_BITS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr      (cfg_we),
        .img_n       (img_n),
        .win_w       (win_w),
        .step_s      (step_s),
        .avg_mode    (pool_mode_reg),
        .s_valid     (s_axis_tvalid),
        .s_ready     (s_axis_tready),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_rd_addr (mem_rd_addr),
        .alu_ctrl    (alu_ctrl),
        .alu_result  (alu_result),
        .m_valid     (m_axis_tvalid),
        .m_ready     (m_axis_tready),
        .m_data      (m_data),
        .m_last      (m_axis_tlast)
    );

    // most recent MAX_WINDOW rows, one slot per row modulo MAX_WINDOW
    pma_row_store #(
        .DEPTH (DEPTH),
        .WIDTH (DATA_BITS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (s_axis_tdata[DATA_BITS-1:0]),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // shared compare/add/divide unit
    pma_alu #(
        .MAX_WINDOW (MAX_WINDOW),
        .DATA_BITS  (DATA_BITS)
    ) u_alu (
        .aclk     (aclk),
        .ctrl     (alu_ctrl),
        .rd_data  (mem_rd_data),
        .win_w    (win_w),
        .avg_mode (pool_mode_reg),
        .result   (alu_result)
    );

    // pad the result to whole bytes
    assign m_axis_tdata = TDATA_W'(m_data);

endmodule

/* hdl/pma_row_store.sv */
// row store memory: one write port, one registered read port
module pma_row_store import pma_pkg::*; #(
    parameter int DEPTH = DEF_MAX_IMAGE * DEF_MAX_WINDOW,
    parameter int WIDTH = DEF_DATA_BITS,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/pma_alu.sv */
// shared arithmetic unit: running max and sum, then a bit-serial divide
module pma_alu import pma_pkg::*; #(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW,
    parameter int DATA_BITS  = DEF_DATA_BITS,
    localparam int WW    = $clog2(MAX_WINDOW + 1),
    localparam int SUM_W = DATA_BITS + $clog2(MAX_WINDOW * MAX_WINDOW) + 1,
    localparam int DIV_W = $clog2(MAX_WINDOW * MAX_WINDOW + 1)
) (
    input  logic                 aclk,
    input  alu_ctrl_t            ctrl,
    input  logic [DATA_BITS-1:0] rd_data,
    input  logic [WW-1:0]        win_w,
    input  logic                 avg_mode,
    output logic [DATA_BITS-1:0] result
);

    localparam int SQ_W = 2 * WW;

    logic signed [DATA_BITS-1:0] best_reg, best_next;
    logic signed [SUM_W-1:0]     sum_reg, sum_next;
    logic [SUM_W-1:0]            quo_reg, quo_next;
    logic [DIV_W-1:0]            rem_reg, rem_next;
    logic [DIV_W-1:0]            div_reg, div_next;
    logic                        neg_reg, neg_next;

    logic signed [DATA_BITS-1:0] pix;
    logic [SQ_W-1:0]             win_sq;
    logic [DIV_W:0]              shifted;
    logic [SUM_W-1:0]            avg_val;

    assign pix    = $signed(rd_data);
    assign win_sq = SQ_W'(win_w) * SQ_W'(win_w);

    always_comb begin
        best_next = best_reg;
        sum_next  = sum_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;
        shifted   = {rem_reg, quo_reg[SUM_W-1]};
        if (ctrl.clear) begin
            best_next = {1'b1, {(DATA_BITS-1){1'b0}}};
            sum_next  = '0;
        end else if (ctrl.acc) begin
            if (pix > best_reg) begin
                best_next = pix;
            end
            sum_next = sum_reg + SUM_W'(pix);
        end else if (ctrl.load) begin
            neg_next = sum_reg[SUM_W-1];
            quo_next = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
            rem_next = '0;
            div_next = DIV_W'(win_sq);
        end else if (ctrl.step) begin
            // restoring step: one quotient bit per cycle
            if (shifted >= (DIV_W+1)'(div_reg)) begin
                rem_next = DIV_W'(shifted - (DIV_W+1)'(div_reg));
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end else begin
                rem_next = DIV_W'(shifted);
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        best_reg <= best_next;
        sum_reg  <= sum_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        neg_reg  <= neg_next;
    end

    assign avg_val = neg_reg ? (~quo_reg + SUM_W'(1)) : quo_reg;
    assign result  = (avg_mode == POOL_AVG) ? avg_val[DATA_BITS-1:0] : best_reg;

endmodule

/* hdl/pma_ctrl.sv */
// sequencer: raster counters, window end tracking, store walk and result register
module pma_ctrl import pma_pkg::*; #(
    parameter int MAX_IMAGE  = DEF_MAX_IMAGE,
    parameter int MAX_WINDOW = DEF_MAX_WINDOW,
    parameter int DATA_BITS  = DEF_DATA_BITS,
    localparam int NW     = $clog2(MAX_IMAGE + 1),
    localparam int WW     = $clog2(MAX_WINDOW + 1),
    localparam int DEPTH  = MAX_IMAGE * MAX_WINDOW,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr,
    input  logic [NW-1:0]         img_n,
    input  logic [WW-1:0]         win_w,
    input  logic [STEP_REG_W-1:0] step_s,
    input  logic                  avg_mode,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  mem_wr_en,
    output logic [ADDR_W-1:0]     mem_wr_addr,
    output logic [ADDR_W-1:0]     mem_rd_addr,
    output alu_ctrl_t             alu_ctrl,
    input  logic [DATA_BITS-1:0]  alu_result,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [DATA_BITS-1:0]  m_data,
    output logic                  m_last
);

    localparam int CNT_W   = $clog2(MAX_IMAGE);
    localparam int RS_W    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int TGT_W   = $clog2(MAX_IMAGE + 2 * (1 << STEP_REG_W));
    localparam int SUM_W   = DATA_BITS + $clog2(MAX_WINDOW * MAX_WINDOW) + 1;
    localparam int DCNT_W  = $clog2(SUM_W);

    pma_state_t state_reg, state_next;

    logic [CNT_W-1:0]  col_reg, col_next;
    logic [CNT_W-1:0]  row_reg, row_next;
    logic [RS_W-1:0]   slot_reg, slot_next;
    logic [TGT_W-1:0]  col_tgt_reg, col_tgt_next;
    logic [TGT_W-1:0]  row_tgt_reg, row_tgt_next;
    logic              last_hit_reg, last_hit_next;
    logic [RS_W-1:0]   ws_reg, ws_next;
    logic [CNT_W-1:0]  wc_reg, wc_next;
    logic [CNT_W-1:0]  cstart_reg, cstart_next;
    logic [WW-1:0]     pc_reg, pc_next;
    logic [WW-1:0]     pr_reg, pr_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic              rd_pend_reg;
    logic              m_valid_reg;
    logic [DATA_BITS-1:0] m_data_reg;
    logic              m_last_reg;

    logic             accept;
    logic             out_free;
    logic             out_load;
    logic [TGT_W-1:0] n_t;
    logic [TGT_W-1:0] w_m1_t;
    logic [WW-1:0]    w_m1;
    logic             col_hit, row_hit, hit;
    logic             col_end, row_end;
    logic             walk_col_last, walk_row_last;
    logic [RS_W-1:0]  slot_inc, ws_inc, ws_start;

    assign accept   = s_valid && (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign n_t      = TGT_W'(img_n);
    assign w_m1     = win_w - WW'(1);
    assign w_m1_t   = TGT_W'(w_m1);

    assign col_hit = (TGT_W'(col_reg) == col_tgt_reg);
    assign row_hit = (TGT_W'(row_reg) == row_tgt_reg);
    assign hit     = col_hit && row_hit;
    assign col_end = (TGT_W'(col_reg) + TGT_W'(1)) >= n_t;
    assign row_end = (TGT_W'(row_reg) + TGT_W'(1)) >= n_t;

    assign walk_col_last = (pc_reg == w_m1);
    assign walk_row_last = (pr_reg == w_m1);

    assign slot_inc = (slot_reg == RS_W'(MAX_WINDOW - 1)) ? '0 : slot_reg + RS_W'(1);
    assign ws_inc   = (ws_reg == RS_W'(MAX_WINDOW - 1)) ? '0 : ws_reg + RS_W'(1);
    // oldest row slot of the window, modulo the store's row count
    assign ws_start = (32'(slot_reg) >= 32'(w_m1))
                    ? RS_W'(32'(slot_reg) - 32'(w_m1))
                    : RS_W'(32'(slot_reg) + 32'(MAX_WINDOW) - 32'(w_m1));

    // next state
    always_comb begin
        state_next = state_reg;
        if (cfg_wr) begin
            state_next = ST_INIT;
        end else begin
            unique case (state_reg)
                ST_INIT:  state_next = ST_IDLE;
                ST_IDLE:  if (accept && hit) state_next = ST_WALK;
                ST_WALK:  if (walk_col_last && walk_row_last) state_next = ST_DRAIN;
                ST_DRAIN: state_next = (avg_mode == POOL_AVG) ? ST_LOAD : ST_OUT;
                ST_LOAD:  state_next = ST_DIV;
                ST_DIV:   if (dcnt_reg == DCNT_W'(SUM_W - 1)) state_next = ST_OUT;
                ST_OUT:   if (out_free) state_next = ST_IDLE;
                default:  state_next = ST_INIT;
            endcase
        end
    end

    // outputs of the sequencer
    always_comb begin
        s_ready        = (state_reg == ST_IDLE);
        mem_wr_en      = accept;
        alu_ctrl.clear = accept && hit;
        alu_ctrl.acc   = rd_pend_reg;
        alu_ctrl.load  = (state_reg == ST_LOAD);
        alu_ctrl.step  = (state_reg == ST_DIV);
        out_load       = (state_reg == ST_OUT) && out_free;
    end

    assign mem_wr_addr = ADDR_W'(ADDR_W'(slot_reg) * ADDR_W'(MAX_IMAGE) + ADDR_W'(col_reg));
    assign mem_rd_addr = ADDR_W'(ADDR_W'(ws_reg) * ADDR_W'(MAX_IMAGE) + ADDR_W'(wc_reg));

    // counters, window targets and walk indexes
    always_comb begin
        col_next      = col_reg;
        row_next      = row_reg;
        slot_next     = slot_reg;
        col_tgt_next  = col_tgt_reg;
        row_tgt_next  = row_tgt_reg;
        last_hit_next = last_hit_reg;
        ws_next       = ws_reg;
        wc_next       = wc_reg;
        cstart_next   = cstart_reg;
        pc_next       = pc_reg;
        pr_next       = pr_reg;
        dcnt_next     = dcnt_reg;
        if (state_reg == ST_INIT) begin
            col_next     = '0;
            row_next     = '0;
            slot_next    = '0;
            col_tgt_next = w_m1_t;
            row_tgt_next = w_m1_t;
        end else if (accept) begin
            if (hit) begin
                last_hit_next = ((col_tgt_reg + TGT_W'(step_s)) >= n_t)
                             && ((row_tgt_reg + TGT_W'(step_s)) >= n_t);
                cstart_next   = col_reg - CNT_W'(w_m1);
                wc_next       = col_reg - CNT_W'(w_m1);
                ws_next       = ws_start;
                pc_next       = '0;
                pr_next       = '0;
            end
            if (col_end) begin
                col_next     = '0;
                col_tgt_next = w_m1_t;
                if (row_end) begin
                    row_next     = '0;
                    slot_next    = '0;
                    row_tgt_next = w_m1_t;
                end else begin
                    row_next  = row_reg + CNT_W'(1);
                    slot_next = slot_inc;
                    if (row_hit) begin
                        row_tgt_next = row_tgt_reg + TGT_W'(step_s);
                    end
                end
            end else begin
                col_next = col_reg + CNT_W'(1);
                if (col_hit) begin
                    col_tgt_next = col_tgt_reg + TGT_W'(step_s);
                end
            end
        end else if (state_reg == ST_WALK) begin
            if (walk_col_last) begin
                pc_next = '0;
                wc_next = cstart_reg;
                pr_next = pr_reg + WW'(1);
                ws_next = ws_inc;
            end else begin
                pc_next = pc_reg + WW'(1);
                wc_next = wc_reg + CNT_W'(1);
            end
        end else if (state_reg == ST_LOAD) begin
            dcnt_next = '0;
        end else if (state_reg == ST_DIV) begin
            dcnt_next = dcnt_reg + DCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            col_reg     <= '0;
            row_reg     <= '0;
            slot_reg    <= '0;
            col_tgt_reg <= '0;
            row_tgt_reg <= '0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            slot_reg    <= slot_next;
            col_tgt_reg <= col_tgt_next;
            row_tgt_reg <= row_tgt_next;
            rd_pend_reg <= (state_reg == ST_WALK);
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        last_hit_reg <= last_hit_next;
        ws_reg       <= ws_next;
        wc_reg       <= wc_next;
        cstart_reg   <= cstart_next;
        pc_reg       <= pc_next;
        pr_reg       <= pr_next;
        dcnt_reg     <= dcnt_next;
        if (out_load) begin
            m_data_reg <= alu_result;
            m_last_reg <= last_hit_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign m_last  = m_last_reg;

    // raster counters stay inside the image and the store; a new image size
    // takes effect while the counters are being cleared
    a_col_in_image: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_INIT) |-> (TGT_W'(col_reg) < n_t))
        else $error("column counter outside image");

    a_slot_in_store: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(slot_reg) < MAX_WINDOW)
        else $error("row slot outside store");

    // a window corner starts the walk over the store
    a_hit_walks: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && hit && !cfg_wr) |=> (state_reg == ST_WALK))
        else $error("window corner did not start a walk");

    // every read issued in the walk is accumulated the next cycle
    a_read_accumulated: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |=> alu_ctrl.acc)
        else $error("store read not accumulated");

    // a finished result always lands in the output register
    a_result_presented: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && out_free) |=> m_valid_reg)
        else $error("result lost at output");

endmodule

/* dv/tb_pool_2d_max_avg.sv */
// self-checking testbench of the 2d max/average pooling block
module tb_pool_2d_max_avg;
    import pma_pkg::*;

    localparam int SIDE_MAX     = DEF_MAX_IMAGE;
    localparam int WIN_MAX      = DEF_MAX_WINDOW;
    localparam int PIX_W        = DEF_DATA_BITS;
    // worst window is 8x8 average; leave room on top
    localparam int SETTLE_CYCLES = 150;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_PIXELS = 1200;
    localparam int CALM_FROM     = 1000;
    localparam int REPORT_MAX    = 10;

    // one pooled result as it should leave the block
    typedef struct {
        logic [PIX_W-1:0] pooled;
        logic             last;
    } pooled_t;

    // tracks the image position, keeps the received pixels of the current
    // image and works out the pooled value for every window that closes
    class pool_predictor;
        logic [IMG_REG_W-1:0]  image_reg  = IMAGE_SIZE_RST;
        logic [WIN_REG_W-1:0]  window_reg = WINDOW_SIZE_RST;
        logic [STEP_REG_W-1:0] step_reg   = STEP_RST;
        logic                  mode_reg   = POOL_MODE_RST;
        int                    row;
        int                    col;
        logic signed [PIX_W-1:0] frame [SIDE_MAX][SIDE_MAX];
        pooled_t               waiting [$];
        int                    mismatches;
        int                    pixels_seen;
        int                    results_seen;
        int                    image_ends;

        // out-of-range register values fold back into the usable range
        function int side();
            if (image_reg == 0) return 1;
            if (image_reg > SIDE_MAX) return SIDE_MAX;
            return image_reg;
        endfunction

        function int span();
            if (window_reg == 0) return 1;
            if (window_reg > WIN_MAX) return WIN_MAX;
            return window_reg;
        endfunction

        function int pitch();
            return (step_reg == 0) ? 1 : step_reg;
        endfunction

        function int pending();
            return waiting.size();
        endfunction

        // any register write restarts the image at the top left corner
        function void apply_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_IMAGE_SIZE:  image_reg  = val[IMG_REG_W-1:0];
                REG_WINDOW_SIZE: window_reg = val[WIN_REG_W-1:0];
                REG_STEP:        step_reg   = val[STEP_REG_W-1:0];
                REG_POOL_MODE:   mode_reg   = val[0];
                default: ;
            endcase
            row = 0;
            col = 0;
        endfunction

        // does a window end at this row or column index, and is it the final one
        function bit closes(int pos, int n, int w, int s, output bit fin);
            int k;
            fin = 1'b0;
            if (n < w || pos + 1 < w) return 1'b0;
            k = pos + 1 - w;
            if (k % s != 0) return 1'b0;
            k = k / s;
            if (k > (n - w) / s) return 1'b0;
            fin = (k == (n - w) / s);
            return 1'b1;
        endfunction

        function void take_pixel(logic [PIX_W-1:0] px);
            int      n, w, s, best, total, q, i, j;
            bit      fin_r, fin_c, hit_r, hit_c;
            pooled_t e;
            n = side();
            w = span();
            s = pitch();
            frame[row][col] = px;
            pixels_seen++;
            hit_r = closes(row, n, w, s, fin_r);
            hit_c = closes(col, n, w, s, fin_c);
            if (hit_r && hit_c) begin
                best  = -(2 ** (PIX_W - 1));
                total = 0;
                for (i = row + 1 - w; i <= row; i++) begin
                    for (j = col + 1 - w; j <= col; j++) begin
                        if (frame[i][j] > best) best = frame[i][j];
                        total += frame[i][j];
                    end
                end
                // int division truncates toward zero
                q = (mode_reg == POOL_AVG) ? total / (w * w) : best;
                e.pooled = q[PIX_W-1:0];
                e.last   = fin_r && fin_c;
                waiting.push_back(e);
            end
            col++;
            if (col >= n) begin
                col = 0;
                row++;
                if (row >= n) row = 0;
            end
        endfunction

        function void note_failure(string what);
            mismatches++;
            if (mismatches <= REPORT_MAX) $display("mismatch: %s", what);
        endfunction

        function void match_result(logic [PIX_W-1:0] got, logic got_last);
            pooled_t e;
            results_seen++;
            if (got_last) image_ends++;
            if (waiting.size() == 0) begin
                note_failure($sformatf("unexpected result pooled %0d last %0b",
                                       $signed(got), got_last));
                return;
            end
            e = waiting.pop_front();
            if (e.pooled !== got || e.last !== got_last)
                note_failure($sformatf(
                    "result %0d expected pooled %0d last %0b, got pooled %0d last %0b",
                    results_seen, $signed(e.pooled), e.last, $signed(got), got_last));
        endfunction
    endclass

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr      = REG_IMAGE_SIZE;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [PIX_W-1:0]      s_axis_tdata  = '0;   // [15:0] pixel
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [PIX_W-1:0]      m_axis_tdata;         // [15:0] pooled
    logic                  m_axis_tlast;

    pool_predictor sb = new();

    // idling knobs, changed per phase; calm switches all idling off
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  calm = 1'b0;
    int  cycles = 0;
    int  settings = 0;

    pool_2d_max_avg i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // hard stop in case the block hangs
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycles, sb.pending());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver back-pressure: random stall bursts
    initial begin : recv_stalls
        @(posedge aclk);
        forever begin
            if (!calm && $urandom_range(0, 99) < recv_stall_pct) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // every result transfer is checked against the oldest expected value
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            sb.match_result(m_axis_tdata, m_axis_tlast);
    end

    // all tasks below start and end right after a rising edge

    // one pixel transfer, with an optional idle burst in front of it
    task automatic send_pixel(input logic [PIX_W-1:0] px);
        if (!calm && $urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_axis_tdata  <= px;
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        sb.take_pixel(px);
    endtask

    // sender pauses until every expected result has come back
    task automatic hold_until_empty();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    // drain, then let a window still being worked run out before touching registers
    task automatic settle();
        hold_until_empty();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // write all four registers back to back; raw values, unused upper bits allowed
    task automatic program_regs(input logic [CFG_DATA_W-1:0] img, win, stp, mode);
        logic [CFG_DATA_W-1:0] vals [4];
        cfg_index_t            idx;
        vals[0] = img;
        vals[1] = win;
        vals[2] = stp;
        vals[3] = mode;
        for (int k = 0; k < 4; k++) begin
            idx = cfg_index_t'(k);
            cfg_we    <= 1'b1;
            cfg_addr  <= idx;
            cfg_wdata <= vals[k];
            @(posedge aclk);
            sb.apply_reg(idx, vals[k]);
        end
        cfg_we <= 1'b0;
        settings++;
    endtask

    // random pixel, leaning on the extremes of the signed range
    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(0, 15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        logic [PIX_W-1:0]      img4x4 [16];
        logic [CFG_DATA_W-1:0] img, win, stp, mode;
        int                    phase, count, n, w, sel, random_pixels;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: 4x4 image, 2x2 max windows at step 2
        // top left window all most-negative, top right holds the positive extreme,
        // bottom left all negative
        img4x4 = '{16'h8000, 16'h8000, 16'h7FFF, 16'h0000,
                   16'h8000, 16'h8000, 16'h8000, 16'h8000,
                   16'hFFFF, 16'hFFFE, 16'h1234, 16'h0100,
                   16'hFFFD, 16'hFFFC, 16'h0001, 16'hFF00};
        for (int k = 0; k < 16; k++) begin
            send_pixel(img4x4[k]);
            // one pause mid-image until the first row of windows is back
            if (k == 7) hold_until_empty();
        end
        settle();

        // zero in every size register folds to 1: each pixel is its own final window
        program_regs(7'd0, 7'd0, 7'd0, {6'd0, POOL_AVG});
        send_pixel(16'h8000);
        send_pixel(16'h7FFF);
        send_pixel(16'hFFFF);
        settle();

        // average of -3 over four pixels must truncate toward zero, not down
        program_regs(7'd2, 7'd2, 7'd1, {6'd0, POOL_AVG});
        send_pixel(16'hFFFF);
        send_pixel(16'h0000);
        send_pixel(16'h0000);
        send_pixel(16'hFFFE);
        settle();

        random_pixels = 0;
        phase = 0;
        while (random_pixels < RANDOM_PIXELS) begin
            calm = (random_pixels >= CALM_FROM);
            send_idle_pct  = 10 * $urandom_range(0, 3);
            recv_stall_pct = 10 * $urandom_range(0, 3);
            case (phase)
                0: begin
                    // all ones: image and window clamp to their maximum, step 15
                    program_regs(7'h7F, 7'h7F, 7'h7F, 7'h7F);
                    count = SIDE_MAX * WIN_MAX;
                end
                1: begin
                    // largest image, 1x1 windows: every pixel yields a result
                    program_regs(7'd64, 7'd1, 7'd1, {6'd0, POOL_MAX});
                    count = 96;
                end
                2: begin
                    // window wider than the image: no results, counters still wrap
                    program_regs(7'd3, 7'd5, 7'd1, {6'd0, POOL_MAX});
                    count = 27;
                end
                default: begin
                    sel = $urandom_range(0, 99);
                    if (sel < 70)      img = 7'($urandom_range(2, 10));
                    else if (sel < 85) img = 7'($urandom_range(11, 20));
                    else if (sel < 92) img = 7'($urandom_range(0, 1));
                    else               img = 7'($urandom_range(21, 127));
                    win = (($urandom_range(0, 9) < 7) ? 7'($urandom_range(1, 4))
                                                       : 7'($urandom_range(0, 15)))
                          | {3'($urandom), 4'd0};
                    stp = (($urandom_range(0, 9) < 6) ? 7'($urandom_range(1, 3))
                                                       : 7'($urandom_range(0, 15)))
                          | {3'($urandom), 4'd0};
                    mode = 7'($urandom);
                    program_regs(img, win, stp, mode);
                    n = sb.side();
                    w = sb.span();
                    if (n * n > 300)
                        // big image: only the first band of windows
                        count = n * w + $urandom_range(0, n);
                    else if ($urandom_range(0, 4) == 0)
                        // cut-off image
                        count = $urandom_range(1, n * n);
                    else
                        count = n * n * $urandom_range(1, 2);
                end
            endcase
            for (int k = 0; k < count; k++) send_pixel(pick_pixel());
            random_pixels += count;
            phase++;
            settle();
        end

        $display("covered %0d pixels over %0d register settings", sb.pixels_seen, settings);
        $display("checked %0d pooled results, %0d of them image ends",
                 sb.results_seen, sb.image_ends);
        if (sb.pending() != 0)
            sb.note_failure($sformatf("%0d expected results never came", sb.pending()));
        if (sb.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
